FILE: hdl/fpq8alu_pkg.sv
package fpq8alu_pkg;

   // Fixed field widths of the two channels.
   localparam int KIND_W   = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   // Default configuration: Q24.8 on a 32-bit word.
   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_BITS_DEF = 32;

   // Operation codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD = 4'd0,
      KIND_SUB = 4'd1,
      KIND_MUL = 4'd2,
      KIND_DIV = 4'd3,
      KIND_GT  = 4'd4,
      KIND_LT  = 4'd5,
      KIND_GE  = 4'd6,
      KIND_LE  = 4'd7,
      KIND_EQ  = 4'd8,
      KIND_NE  = 4'd9,
      KIND_MIN = 4'd10,
      KIND_MAX = 4'd11,
      KIND_INC = 4'd12,
      KIND_DEC = 4'd13
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_OVF  = 2'd1,
      STATUS_DIV0 = 2'd2
   } status_type;

endpackage

FILE: hdl/fpq8alu_req_if.sv
interface fpq8alu_req_if;
   logic                                     valid;
   logic                                     ready;
   logic        [fpq8alu_pkg::KIND_W-1:0]    kind;
   logic signed [fpq8alu_pkg::DATA_W-1:0]    operand_a;
   logic signed [fpq8alu_pkg::DATA_W-1:0]    operand_b;

   modport source (output valid, kind, operand_a, operand_b, input ready);
   modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

FILE: hdl/fpq8alu_rsp_if.sv
interface fpq8alu_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [fpq8alu_pkg::DATA_W-1:0]    result_raw;
   logic                                     condition;
   logic        [fpq8alu_pkg::STATUS_W-1:0]  status;

   modport source (output valid, result_raw, condition, status, input ready);
   modport sink   (input valid, result_raw, condition, status, output ready);
endinterface

FILE: hdl/fixed_point_q8_alu_core.sv
// Channel    Dir  Fields                          Transfer
// req_chan   in   kind, operand_a, operand_b      valid && ready
// rsp_chan   out  result_raw, condition, status   valid && ready
//
// Every item passes stages A, B and C, the restoring divider and stages E and
// F; the divider, which sets most of the pipeline length, resolves one quotient
// bit per stage. The default format is Q24.8 on 32 bits; WORD_BITS is capped at 32.
// One item can be accepted every cycle while rsp_chan does not hold the pipeline.
// Reset is synchronous and clears only the stage valid bits.
// The whole pipeline holds while a finished result waits on rsp_chan.

module fixed_point_q8_alu_core #(
   parameter int FRAC_BITS = fpq8alu_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = fpq8alu_pkg::WORD_BITS_DEF
) (
   input logic           clock,
   input logic           reset,
   fpq8alu_req_if.sink   req_chan,
   fpq8alu_rsp_if.source rsp_chan
);

   localparam int EFF   = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int SH    = 32 - EFF;
   localparam int NB    = EFF + FRAC_BITS;
   localparam int RW    = EFF + 1;
   localparam int MAG_W = 64;
   localparam int DEPTH = NB + 5;

   localparam longint WMAX_L = (longint'(1) << (EFF - 1)) - 1;
   localparam logic signed [31:0] WMAX_W = 32'(WMAX_L);
   localparam logic signed [31:0] WMIN_W = 32'(-WMAX_L - 1);
   localparam logic signed [32:0] WMAX_S = 33'(WMAX_L);
   localparam logic signed [32:0] WMIN_S = 33'(-WMAX_L - 1);
   localparam logic [MAG_W-1:0]   POS_LIM = MAG_W'(WMAX_L);
   localparam logic [MAG_W-1:0]   NEG_LIM = MAG_W'(WMAX_L + 1);
   localparam logic [63:0]        HALF    = 64'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      fpq8alu_pkg::kind_type   kind;
      logic                    neg;
      logic signed [31:0]      res;
      logic                    cond;
      fpq8alu_pkg::status_type st;
      logic [MAG_W-1:0]        mag;
      logic [RW-1:0]           rem;
      logic [NB-1:0]           nq;
      logic [EFF-1:0]          den;
   } pipe_type;

   typedef struct packed {
      logic signed [31:0]      res;
      logic                    cond;
      fpq8alu_pkg::status_type st;
   } out_type;

   logic             advance;
   logic             take;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   // Global stall: every stage moves when the output register is empty or rsp_chan is ready.
   assign advance        = !vld_ff[DEPTH-1] || rsp_chan.ready;
   assign take           = req_chan.valid && advance;
   assign req_chan.ready = advance;
   assign vld_in         = {vld_ff[DEPTH-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage A: sign-extend to the working width and take magnitudes.
   logic signed [31:0]    a_sh, b_sh, a_in, b_in;
   logic [31:0]           ma_in, mb_in;
   fpq8alu_pkg::kind_type k_in;
   fpq8alu_pkg::kind_type k_a_ff;
   logic signed [31:0]    a_a_ff, b_a_ff;
   logic [31:0]           ma_a_ff, mb_a_ff;

   always_comb begin
      a_sh  = req_chan.operand_a << SH;
      b_sh  = req_chan.operand_b << SH;
      a_in  = a_sh >>> SH;
      b_in  = b_sh >>> SH;
      ma_in = a_in[31] ? (~a_in + 32'd1) : a_in;
      mb_in = b_in[31] ? (~b_in + 32'd1) : b_in;
      k_in  = fpq8alu_pkg::kind_type'(req_chan.kind);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k_a_ff  <= k_in;
         a_a_ff  <= a_in;
         b_a_ff  <= b_in;
         ma_a_ff <= ma_in;
         mb_a_ff <= mb_in;
      end
   end

   // Stage B: multiplier, the short operations and divider setup.
   logic signed [32:0] ax, bx, wide;
   logic               arith;
   pipe_type           b_in_p, b_ff;
   logic [63:0]        prod_in, prod_ff;

   always_comb begin
      ax            = {a_a_ff[31], a_a_ff};
      bx            = {b_a_ff[31], b_a_ff};
      wide          = '0;
      arith         = 1'b0;
      b_in_p        = '0;
      b_in_p.kind   = k_a_ff;
      b_in_p.neg    = a_a_ff[31] ^ b_a_ff[31];
      b_in_p.st     = fpq8alu_pkg::STATUS_OK;
      b_in_p.nq     = {ma_a_ff[EFF-1:0], {FRAC_BITS{1'b0}}};
      b_in_p.den    = mb_a_ff[EFF-1:0];
      case (k_a_ff)
         fpq8alu_pkg::KIND_ADD: begin
            wide  = ax + bx;
            arith = 1'b1;
         end
         fpq8alu_pkg::KIND_SUB: begin
            wide  = ax - bx;
            arith = 1'b1;
         end
         fpq8alu_pkg::KIND_INC: begin
            wide  = ax + 33'sd1;
            arith = 1'b1;
         end
         fpq8alu_pkg::KIND_DEC: begin
            wide  = ax - 33'sd1;
            arith = 1'b1;
         end
         fpq8alu_pkg::KIND_DIV: begin
            if (b_a_ff == '0) begin
               b_in_p.st = fpq8alu_pkg::STATUS_DIV0;
            end
         end
         fpq8alu_pkg::KIND_GT:  b_in_p.cond = (a_a_ff > b_a_ff);
         fpq8alu_pkg::KIND_LT:  b_in_p.cond = (a_a_ff < b_a_ff);
         fpq8alu_pkg::KIND_GE:  b_in_p.cond = (a_a_ff >= b_a_ff);
         fpq8alu_pkg::KIND_LE:  b_in_p.cond = (a_a_ff <= b_a_ff);
         fpq8alu_pkg::KIND_EQ:  b_in_p.cond = (a_a_ff == b_a_ff);
         fpq8alu_pkg::KIND_NE:  b_in_p.cond = (a_a_ff != b_a_ff);
         fpq8alu_pkg::KIND_MIN: b_in_p.res  = (a_a_ff < b_a_ff) ? a_a_ff : b_a_ff;
         fpq8alu_pkg::KIND_MAX: b_in_p.res  = (a_a_ff > b_a_ff) ? a_a_ff : b_a_ff;
         default: ;
      endcase
      // Saturate the add-type results to the working range.
      if (arith) begin
         if (wide > WMAX_S) begin
            b_in_p.res = WMAX_W;
            b_in_p.st  = fpq8alu_pkg::STATUS_OVF;
         end else if (wide < WMIN_S) begin
            b_in_p.res = WMIN_W;
            b_in_p.st  = fpq8alu_pkg::STATUS_OVF;
         end else begin
            b_in_p.res = wide[31:0];
         end
      end
      prod_in = 64'(ma_a_ff) * 64'(mb_a_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ff    <= b_in_p;
         prod_ff <= prod_in;
      end
   end

   // Stage C: round the product magnitude; this stage also feeds the divider.
   pipe_type div_ff [0:NB];
   pipe_type c_in;

   always_comb begin
      c_in = b_ff;
      if (b_ff.kind == fpq8alu_pkg::KIND_MUL) begin
         c_in.mag = (prod_ff + HALF) >> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= c_in;
      end
   end

   // Restoring divider: one quotient bit per stage, shifted into nq.
   for (genvar k = 0; k < NB; k++) begin : g_div
      logic [RW-1:0] rem_sh;
      logic          fits;
      pipe_type      step_in;

      always_comb begin
         step_in = div_ff[k];
         rem_sh  = {div_ff[k].rem[RW-2:0], div_ff[k].nq[NB-1]};
         fits    = (rem_sh >= RW'(div_ff[k].den));
         step_in.rem = fits ? (rem_sh - RW'(div_ff[k].den)) : rem_sh;
         step_in.nq  = {div_ff[k].nq[NB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[k+1] <= step_in;
         end
      end
   end

   // Stage E: round the quotient half away from zero.
   pipe_type e_in, e_ff;
   logic     round_up;

   always_comb begin
      e_in     = div_ff[NB];
      round_up = ({div_ff[NB].rem, 1'b0} >= (RW + 1)'(div_ff[NB].den));
      if (div_ff[NB].kind == fpq8alu_pkg::KIND_DIV) begin
         e_in.mag = MAG_W'(div_ff[NB].nq) + MAG_W'(round_up);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff <= e_in;
      end
   end

   // Stage F: saturate and sign the multiply and divide results.
   out_type f_in, f_ff;
   logic    use_mag;

   always_comb begin
      f_in.res  = e_ff.res;
      f_in.cond = e_ff.cond;
      f_in.st   = e_ff.st;
      use_mag   = (e_ff.kind == fpq8alu_pkg::KIND_MUL)
               || ((e_ff.kind == fpq8alu_pkg::KIND_DIV)
                   && (e_ff.st != fpq8alu_pkg::STATUS_DIV0));
      if (use_mag) begin
         if (!e_ff.neg && (e_ff.mag > POS_LIM)) begin
            f_in.res = WMAX_W;
            f_in.st  = fpq8alu_pkg::STATUS_OVF;
         end else if (e_ff.neg && (e_ff.mag > NEG_LIM)) begin
            f_in.res = WMIN_W;
            f_in.st  = fpq8alu_pkg::STATUS_OVF;
         end else if (e_ff.neg) begin
            f_in.res = ~e_ff.mag[31:0] + 32'd1;
         end else begin
            f_in.res = e_ff.mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_ff <= f_in;
      end
   end

   assign rsp_chan.valid      = vld_ff[DEPTH-1];
   assign rsp_chan.result_raw = f_ff.res;
   assign rsp_chan.condition  = f_ff.cond;
   assign rsp_chan.status     = f_ff.st;

   // A divide by zero leaves a zero result and no condition.
   a_div0_clean: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-1] && (f_ff.st == fpq8alu_pkg::STATUS_DIV0)
      |-> (f_ff.res == '0) && !f_ff.cond)
      else $error("divide by zero with nonzero result");

   // A comparison outcome comes with a zero result and ok status.
   a_cond_clean: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-1] && f_ff.cond
      |-> (f_ff.res == '0) && (f_ff.st == fpq8alu_pkg::STATUS_OK))
      else $error("condition set beside an arithmetic result");

   // Overflow always lands on one of the two bounds.
   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-1] && (f_ff.st == fpq8alu_pkg::STATUS_OVF)
      |-> (f_ff.res == WMAX_W) || (f_ff.res == WMIN_W))
      else $error("overflow result not saturated");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   // A stall freezes every stage valid bit.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("stage valid changed during a stall");

endmodule

FILE: tb/fixed_point_q8_alu_core_test.sv
module fixed_point_q8_alu_core_test;

   localparam int FRAC = fpq8alu_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = 45;
   localparam int N_RANDOM = 1300;

   typedef struct packed {
      logic signed [fpq8alu_pkg::DATA_W-1:0] result_raw;
      logic                                  condition;
      logic [fpq8alu_pkg::STATUS_W-1:0]      status;
   } alu_result_type;

   // Computes the expected outcome of one operation on raw Q24.8 words.
   function automatic alu_result_type compute_alu(logic [fpq8alu_pkg::KIND_W-1:0] kind,
                                                  logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      longint sa, sb, wide;
      logic [63:0] ma, mb, mag, n, d;
      logic neg;
      sa = a;
      sb = b;
      r = '0;
      wide = 0;
      neg = (sa < 0) != (sb < 0);
      ma = (sa < 0) ? -sa : sa;
      mb = (sb < 0) ? -sb : sb;
      case (kind)
         fpq8alu_pkg::KIND_ADD: wide = sa + sb;
         fpq8alu_pkg::KIND_SUB: wide = sa - sb;
         fpq8alu_pkg::KIND_INC: wide = sa + 1;
         fpq8alu_pkg::KIND_DEC: wide = sa - 1;
         fpq8alu_pkg::KIND_MUL: begin
            mag = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
            wide = neg ? -longint'(mag) : longint'(mag);
         end
         fpq8alu_pkg::KIND_DIV: begin
            if (sb == 0) begin
               r.status = fpq8alu_pkg::STATUS_DIV0;
            end else begin
               n = ma << FRAC;
               d = mb;
               mag = (2 * n + d) / (2 * d);
               wide = neg ? -longint'(mag) : longint'(mag);
            end
         end
         fpq8alu_pkg::KIND_GT: r.condition = sa > sb;
         fpq8alu_pkg::KIND_LT: r.condition = sa < sb;
         fpq8alu_pkg::KIND_GE: r.condition = sa >= sb;
         fpq8alu_pkg::KIND_LE: r.condition = sa <= sb;
         fpq8alu_pkg::KIND_EQ: r.condition = sa == sb;
         fpq8alu_pkg::KIND_NE: r.condition = sa != sb;
         fpq8alu_pkg::KIND_MIN: wide = (sa < sb) ? sa : sb;
         fpq8alu_pkg::KIND_MAX: wide = (sa > sb) ? sa : sb;
         default: ;
      endcase
      // Saturate to the 32-bit signed range.
      if (wide > 64'sd2147483647) begin
         wide = 64'sd2147483647;
         r.status = fpq8alu_pkg::STATUS_OVF;
      end else if (wide < -64'sd2147483648) begin
         wide = -64'sd2147483648;
         r.status = fpq8alu_pkg::STATUS_OVF;
      end
      r.result_raw = wide[31:0];
      return r;
   endfunction

   int error_count = 0;

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   class alu_scoreboard;
      alu_result_type pending_results[$];

      function void note_request(logic [fpq8alu_pkg::KIND_W-1:0] kind,
                                 logic signed [31:0] a, logic signed [31:0] b);
         pending_results.push_back(compute_alu(kind, a, b));
      endfunction

      task check_result(alu_result_type got);
         alu_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
         end
         want = pending_results.pop_front();
         if (got.result_raw !== want.result_raw)
            report_mismatch($sformatf("result_raw %h, expected %h",
                                      got.result_raw, want.result_raw));
         if (got.condition !== want.condition)
            report_mismatch($sformatf("condition %b, expected %b",
                                      got.condition, want.condition));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got.status, want.status));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   fpq8alu_req_if req_chan();
   fpq8alu_rsp_if rsp_chan();

   fixed_point_q8_alu_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   alu_scoreboard scoreboard = new();
   bit calm_phase = 0;
   bit hold_off = 0;
   bit stimulus_done = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.kind = '0;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      rsp_chan.ready = 0;
   end

   // Note each accepted transfer on both channels.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         scoreboard.note_request(req_chan.kind, req_chan.operand_a, req_chan.operand_b);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         scoreboard.check_result({rsp_chan.result_raw, rsp_chan.condition,
                                  rsp_chan.status});
   end

   // Sends one item and waits for its transfer, sometimes with a random gap first outside the calm phase.
   task automatic send_item(logic [fpq8alu_pkg::KIND_W-1:0] kind, logic [31:0] a,
                            logic [31:0] b);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.kind <= kind;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 2047) - 1024;
         3: return {{16{1'b0}}, 16'($urandom)};
         4: return 32'($signed(16'($urandom)));
         5: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Receiver: random stalls, one long hold-off, none near the end.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_chan.ready <= 0;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_chan.ready <= 1;
      end
   end

   initial begin
      logic [31:0] edge_vals[6];
      edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h100, 32'hffffff00, 32'h1};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: every operation at the field extremes, and the special cases.
      for (int k = 0; k < 14; k++)
         send_item(4'(k), edge_vals[k % 6], edge_vals[(k + 1) % 6]);
      send_item(fpq8alu_pkg::KIND_DIV, 32'h1234, 32'h0);
      send_item(fpq8alu_pkg::KIND_DIV, 32'h80000000, 32'hffffffff);
      send_item(fpq8alu_pkg::KIND_MUL, 32'h7fffffff, 32'h7fffffff);
      send_item(fpq8alu_pkg::KIND_MUL, 32'h00000080, 32'h00000001);
      send_item(fpq8alu_pkg::KIND_MUL, 32'hffffff80, 32'h00000001);
      send_item(fpq8alu_pkg::KIND_DIV, 32'h00000001, 32'h00000200);
      send_item(fpq8alu_pkg::KIND_ADD, 32'h80000000, 32'h80000000);
      send_item(fpq8alu_pkg::KIND_SUB, 32'h7fffffff, 32'h80000000);
      send_item(fpq8alu_pkg::KIND_INC, 32'h7fffffff, 32'hffffffff);
      send_item(fpq8alu_pkg::KIND_DEC, 32'h80000000, 32'h0);
      send_item(4'd14, 32'h5, 32'h6);
      send_item(4'd15, 32'hffffffff, 32'hffffffff);
      hold_off = 1;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 200) calm_phase = 1;
         send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      end
      req_chan.valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("fixed_point_q8_alu_core_test passed");
      else
         $display("fixed_point_q8_alu_core_test failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("fixed_point_q8_alu_core_test failed");
      $finish;
   end
endmodule
